/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// trigger implies condition in the same cycle
`define CHK_IMPLY(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// trigger implies condition in the following cycle
`define CHK_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* hdl/ptts_pkg.sv */
// types, constants and helpers of the periodic task tick scheduler
package ptts_pkg;

  localparam int NUM_CORES = 2;
  localparam int MAX_TASKS = 16;

  localparam int DATA_W   = 16;
  localparam int ENTRIES  = NUM_CORES * MAX_TASKS;
  localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CORE_IW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int TIDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W    = $clog2(MAX_TASKS + 1);
  localparam int MASK_CORES = (NUM_CORES < 2) ? NUM_CORES : 2;

  localparam logic [DATA_W-1:0] WDT_RELOAD_RST = 16'd1000;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_START    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_FIRE = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic              core;
    logic [3:0]        task_index;
    logic              add_ok;
    logic [DATA_W-1:0] missed_ticks;
    logic [1:0]        wdt_mask;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_cd;
    logic              wr_per;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_cd_data;
    logic [DATA_W-1:0] wr_per_data;
  } mem_req_t;

  // flat table address of task t of core c
  function automatic logic [ADDR_W-1:0] entry_addr(logic [CORE_IW-1:0] c,
                                                   logic [TIDX_W-1:0] t);
    return ADDR_W'(int'(c) * MAX_TASKS + int'(t));
  endfunction

endpackage

/* hdl/ptts_mem.sv */
// countdown and period tables, one write and one registered read port each
module ptts_mem (
  input  logic                      clk,
  input  ptts_pkg::mem_req_t        req,
  output logic [ptts_pkg::DATA_W-1:0] rd_countdown,
  output logic [ptts_pkg::DATA_W-1:0] rd_period
);
  import ptts_pkg::*;

  logic [DATA_W-1:0] countdown_mem [ENTRIES];
  logic [DATA_W-1:0] period_mem    [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_cd) begin
      countdown_mem[req.wr_addr] <= req.wr_cd_data;
    end
    if (req.wr_per) begin
      period_mem[req.wr_addr] <= req.wr_per_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_countdown <= countdown_mem[req.rd_addr];
      rd_period    <= period_mem[req.rd_addr];
    end
  end

endmodule

/* hdl/ptts_unit.sv */
// shared countdown unit: decrement a nonzero countdown on tick or start, reload a zero one on dispatch
module ptts_unit (
  input  logic                        reload_mode,
  input  logic [ptts_pkg::DATA_W-1:0] cd,
  input  logic [ptts_pkg::DATA_W-1:0] per,
  output logic                        wr,
  output logic                        fire,
  output logic [ptts_pkg::DATA_W-1:0] val
);
  import ptts_pkg::*;

  logic is_zero;

  assign is_zero = (cd == '0);
  assign fire    = reload_mode && is_zero;
  assign wr      = reload_mode ? is_zero : !is_zero;
  assign val     = reload_mode ? per : cd - DATA_W'(1);

endmodule

/* hdl/ptts_seq.sv */
// command sequencer: task counts, watchdogs, tick count and the table walk
module ptts_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  cmd,
  input  logic                        core,
  input  logic [ptts_pkg::DATA_W-1:0] offset,
  input  logic [ptts_pkg::DATA_W-1:0] period,
  input  logic [ptts_pkg::DATA_W-1:0] wdt_reload,
  input  logic                        out_free,
  output ptts_pkg::mem_req_t          mem_req,
  input  logic [ptts_pkg::DATA_W-1:0] rd_countdown,
  input  logic [ptts_pkg::DATA_W-1:0] rd_period,
  output logic                        emit,
  output ptts_pkg::result_t           emit_res
);
  import ptts_pkg::*;

  localparam logic [CORE_IW-1:0] LAST_CORE = CORE_IW'(NUM_CORES - 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  tcount    [NUM_CORES];
  logic [DATA_W-1:0] wdog      [NUM_CORES];
  logic [31:0]       last_seen [NUM_CORES];
  logic [31:0]       tick_count;

  result_t            res;
  logic               walk_all;
  logic               walk_dispatch;
  logic [CORE_IW-1:0] pcore;
  logic [CNT_W-1:0]   ptask;
  logic               ptr_done;
  logic               p_v;
  logic [ADDR_W-1:0]  p_addr;
  logic [TIDX_W-1:0]  p_task;

  cmd_t               cmd_in;
  logic [CORE_IW-1:0] lcore;
  logic               core_ok;
  logic               add_room;
  logic               run;
  logic [31:0]        dm1;
  logic [DATA_W-1:0]  missed;
  logic [DATA_W:0]    cd_init;
  logic [1:0]         mask;
  logic [DATA_W-1:0]  wdog_dec [NUM_CORES];
  logic               cur_has;

  logic accept, advance, consume, rd_en, ptr_next_core, ptr_finish;
  logic u_wr, u_fire;
  logic [DATA_W-1:0] u_val;

  assign cmd_in   = cmd_t'(cmd);
  assign lcore    = CORE_IW'(core);
  assign core_ok  = 32'(core) < NUM_CORES;
  assign add_room = core_ok && (tcount[lcore] < CNT_W'(MAX_TASKS));
  assign run      = core_ok && (last_seen[lcore] < tick_count);
  // elapsed ticks minus one
  assign dm1      = tick_count + ~last_seen[lcore];
  assign missed   = !run ? '0 : ((|dm1[31:DATA_W]) ? '1 : dm1[DATA_W-1:0]);
  assign cd_init  = {1'b0, offset} + (DATA_W+1)'(1);
  assign cur_has  = !ptr_done && (ptask < tcount[pcore]);

  always_comb begin
    mask = '0;
    for (int c = 0; c < NUM_CORES; c++) begin
      wdog_dec[c] = (wdog[c] != '0) ? wdog[c] - DATA_W'(1) : '0;
    end
    for (int c = 0; c < MASK_CORES; c++) begin
      mask[c] = (wdog[c] == DATA_W'(1));
    end
  end

  ptts_unit u_unit (
    .reload_mode (walk_dispatch),
    .cd          (rd_countdown),
    .per         (rd_period),
    .wr          (u_wr),
    .fire        (u_fire),
    .val         (u_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    item_stall    = 1'b1;
    accept        = 1'b0;
    advance       = 1'b0;
    consume       = 1'b0;
    rd_en         = 1'b0;
    ptr_next_core = 1'b0;
    ptr_finish    = 1'b0;
    emit          = 1'b0;
    emit_res      = res;
    mem_req       = '0;
    unique case (state)
      ST_IDLE: begin
        // no transfer while reset is applied
        item_stall = rst;
        accept     = item_valid && !rst;
        if (accept) begin
          unique case (cmd_in)
            CMD_ADD: begin
              state_next = ST_DONE;
              if (add_room) begin
                mem_req.wr_cd       = 1'b1;
                mem_req.wr_per      = 1'b1;
                mem_req.wr_addr     = entry_addr(lcore, tcount[lcore][TIDX_W-1:0]);
                mem_req.wr_cd_data  = cd_init[DATA_W] ? '1 : cd_init[DATA_W-1:0];
                mem_req.wr_per_data = period;
              end
            end
            CMD_TICK, CMD_START: state_next = ST_WALK;
            CMD_DISPATCH:        state_next = run ? ST_WALK : ST_DONE;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        // a fired entry waits until its transfer can be loaded
        consume       = !(p_v && u_fire) || out_free;
        advance       = !p_v || consume;
        rd_en         = advance && cur_has;
        mem_req.rd_en = rd_en;
        mem_req.rd_addr = entry_addr(pcore, ptask[TIDX_W-1:0]);
        if (p_v && consume && u_wr) begin
          mem_req.wr_cd      = 1'b1;
          mem_req.wr_addr    = p_addr;
          mem_req.wr_cd_data = u_val;
        end
        if (p_v && u_fire && out_free) begin
          emit     = 1'b1;
          emit_res = '{kind: KIND_FIRE, core: res.core, task_index: 4'(p_task),
                       add_ok: 1'b0, missed_ticks: '0, wdt_mask: '0, last: 1'b0};
        end
        if (!ptr_done && !cur_has) begin
          if (walk_all && pcore != LAST_CORE) begin
            ptr_next_core = 1'b1;
          end else begin
            ptr_finish = 1'b1;
          end
        end
        if (ptr_done && !p_v) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      tcount     <= '{default: '0};
      wdog       <= '{default: '0};
      last_seen  <= '{default: '0};
      tick_count <= '0;
      ptr_done   <= 1'b1;
      p_v        <= 1'b0;
    end else if (accept) begin
      p_v      <= 1'b0;
      ptr_done <= 1'b0;
      unique case (cmd_in)
        CMD_ADD: begin
          if (add_room) begin
            tcount[lcore] <= tcount[lcore] + CNT_W'(1);
          end
        end
        CMD_TICK: begin
          for (int c = 0; c < NUM_CORES; c++) begin
            wdog[c] <= wdog_dec[c];
          end
          tick_count <= tick_count + 32'd1;
        end
        CMD_DISPATCH: begin
          if (core_ok) begin
            wdog[lcore] <= wdt_reload;
            if (run) begin
              last_seen[lcore] <= tick_count;
            end
          end
        end
        CMD_START: begin
          for (int c = 0; c < NUM_CORES; c++) begin
            wdog[c]      <= wdt_reload;
            last_seen[c] <= '0;
          end
          tick_count <= 32'd1;
        end
        default: ;
      endcase
    end else if (state == ST_WALK) begin
      if (ptr_finish) begin
        ptr_done <= 1'b1;
      end
      if (advance) begin
        p_v <= rd_en;
      end
    end
  end

  // latched reply and walk pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      walk_all      <= (cmd_in == CMD_TICK) || (cmd_in == CMD_START);
      walk_dispatch <= (cmd_in == CMD_DISPATCH);
      pcore         <= ((cmd_in == CMD_DISPATCH) && core_ok) ? lcore : '0;
      ptask         <= '0;
      unique case (cmd_in)
        CMD_ADD: res <= '{kind: KIND_ADD, core: core,
                          task_index: add_room ? 4'(tcount[lcore]) : 4'd0,
                          add_ok: add_room, missed_ticks: '0, wdt_mask: '0,
                          last: 1'b1};
        CMD_TICK, CMD_START: res <= '{kind: KIND_TICK, core: 1'b0, task_index: 4'd0,
                                      add_ok: 1'b0, missed_ticks: '0,
                                      wdt_mask: mask, last: 1'b1};
        CMD_DISPATCH: res <= '{kind: KIND_DONE, core: core, task_index: 4'd0,
                               add_ok: 1'b0, missed_ticks: missed, wdt_mask: '0,
                               last: 1'b1};
        default: res <= res;
      endcase
    end else if (state == ST_WALK) begin
      if (rd_en) begin
        ptask <= ptask + CNT_W'(1);
      end else if (ptr_next_core) begin
        pcore <= pcore + CORE_IW'(1);
        ptask <= '0;
      end
      if (advance) begin
        p_addr <= mem_req.rd_addr;
        p_task <= ptask[TIDX_W-1:0];
      end
    end
  end

endmodule

/* hdl/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler: two cores of up to 16 periodic tasks each, one
// watchdog per core. Items are taken one at a time; the input stalls until the
// last result of the current item has been loaded into the output register.
// An add writes its table entry when it is accepted. A tick or start walks
// every added task of every core through one countdown unit fed by a single
// registered read port, one entry per cycle. A dispatch pass walks the
// addressed core only, or none when no tick elapsed since its previous pass;
// a fired task waits while the result output is stalled. No clearing pass
// follows reset: entries beyond a core's task count are never read. wdt_reload
// is written over its own transfer channel, which is always ready, and must
// only change while idle.
module periodic_task_tick_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic        core,
  input  logic [15:0] offset,
  input  logic [15:0] period,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic        out_core,
  output logic [3:0]  task_index,
  output logic        add_ok,
  output logic [15:0] missed_ticks,
  output logic [1:0]  wdt_expired_mask,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ptts_pkg::*;

  logic [DATA_W-1:0] wdt_reload;
  logic              out_free;
  logic              emit;
  result_t           emit_res;
  result_t           res;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_countdown;
  logic [DATA_W-1:0] rd_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wdt_reload <= WDT_RELOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      wdt_reload <= cfg_data;
    end
  end

  ptts_mem u_mem (
    .clk          (clk),
    .req          (mem_req),
    .rd_countdown (rd_countdown),
    .rd_period    (rd_period)
  );

  ptts_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .core         (core),
    .offset       (offset),
    .period       (period),
    .wdt_reload   (wdt_reload),
    .out_free     (out_free),
    .mem_req      (mem_req),
    .rd_countdown (rd_countdown),
    .rd_period    (rd_period),
    .emit         (emit),
    .emit_res     (emit_res)
  );

  // output register, reloaded whenever it is empty or its transfer completes
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      res <= emit_res;
    end
  end

  assign kind             = res.kind;
  assign out_core         = res.core;
  assign task_index       = res.task_index;
  assign add_ok           = res.add_ok;
  assign missed_ticks     = res.missed_ticks;
  assign wdt_expired_mask = res.wdt_mask;
  assign last             = res.last;

endmodule

/* hdl/ptts_checker.sv */
// port level checks of the scheduler, bound to the top level
`include "assert_macros.svh"

module ptts_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic        out_core,
  input logic [3:0]  task_index,
  input logic        add_ok,
  input logic [15:0] missed_ticks,
  input logic [1:0]  wdt_expired_mask,
  input logic        last
);
  import ptts_pkg::*;

  `CHK_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(kind) && $stable(out_core) && $stable(task_index) && $stable(missed_ticks) && $stable(last), "stalled result changed")

  `CHK_NEXT(a_busy_after_item, clk, rst, item_valid && !item_stall, item_stall, "input not stalled after a transfer")

  `CHK_IMPLY(a_fire_not_last, clk, rst, result_valid && (kind == KIND_FIRE), !last && !add_ok, "fired task marked last")

  `CHK_IMPLY(a_single_replies, clk, rst, result_valid && ((kind == KIND_ADD) || (kind == KIND_TICK)), last, "add or tick reply not last")

  `CHK_IMPLY(a_mask_on_tick, clk, rst, result_valid && (kind != KIND_TICK), wdt_expired_mask == 2'b00, "watchdog mask outside tick reply")

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);
